[hdl/ctw_pkg.sv]
// Shared types, constants and ring geometry for the control transfer TRB writer.
`timescale 1ns / 1ps
package ctw_pkg;

  localparam int RING_DEPTH = 64;
  localparam int SLOT_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int LAST_SLOT  = RING_DEPTH - 1;

  localparam logic [5:0] TRB_SETUP  = 6'd2;
  localparam logic [5:0] TRB_DATA   = 6'd3;
  localparam logic [5:0] TRB_STATUS = 6'd4;
  localparam logic [5:0] TRB_LINK   = 6'd6;

  localparam logic [1:0] TRT_NONE = 2'd0;
  localparam logic [1:0] TRT_OUT  = 2'd2;
  localparam logic [1:0] TRT_IN   = 2'd3;

  localparam logic [31:0] BIT_TC     = 32'h0000_0002;
  localparam logic [31:0] BIT_IOC    = 32'h0000_0020;
  localparam logic [31:0] BIT_IDT    = 32'h0000_0040;
  localparam logic [31:0] BIT_DIR_IN = 32'h0001_0000;

  localparam logic [31:0] SETUP_LEN = 32'd8;

  typedef struct packed {
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] request_value;
    logic [15:0] request_index;
    logic [15:0] data_length;
    logic [63:0] buffer_address;
  } req_t;

  typedef struct packed {
    logic [5:0]  ring_slot;
    logic [31:0] param_low;
    logic [31:0] param_high;
    logic [31:0] status_word;
    logic [31:0] control_word;
    logic        last_trb;
  } trb_t;

  typedef struct packed {
    logic [31:0] setup_low;
    logic [31:0] setup_high;
    logic [31:0] setup_ctl;
    logic        has_data;
    logic [63:0] data_addr;
    logic [15:0] data_len;
    logic [31:0] data_ctl;
    logic [31:0] status_ctl;
  } cmd_t;

endpackage

[hdl/ctw_front.sv]
// Request decoder and command queue feeding the TRB sequencer.
`timescale 1ns / 1ps
module ctw_front import ctw_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  req_t request,
  output logic cmd_valid,
  input  logic cmd_pop,
  output cmd_t cmd
);

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;
  cmd_t       decoded;
  logic       is_in;
  logic       len_nz;
  logic [1:0] trt;
  logic       push_ok;
  logic       pop_ok;

  always_comb begin
    is_in  = request.request_type[7];
    len_nz = (request.data_length != 16'd0);
    trt    = len_nz ? (is_in ? TRT_IN : TRT_OUT) : TRT_NONE;
    decoded.setup_low  = {request.request_value, request.request_code, request.request_type};
    decoded.setup_high = {request.data_length, request.request_index};
    decoded.setup_ctl  = ({30'd0, trt} << 16) | ({26'd0, TRB_SETUP} << 10) | BIT_IDT;
    decoded.has_data   = len_nz && (request.buffer_address != 64'd0);
    decoded.data_addr  = request.buffer_address;
    decoded.data_len   = request.data_length;
    decoded.data_ctl   = ({26'd0, TRB_DATA} << 10) | (is_in ? BIT_DIR_IN : 32'd0) | BIT_IOC;
    decoded.status_ctl = ({26'd0, TRB_STATUS} << 10)
                       | ((!len_nz || !is_in) ? BIT_DIR_IN : 32'd0) | BIT_IOC;
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign push_ok   = push && !full;
  assign pop_ok    = cmd_pop && cmd_valid;
  assign cmd       = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (push_ok && !pop_ok) begin
      count_next = count + 2'd1;
    end else if (pop_ok && !push_ok) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      entries[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_ok) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_ok) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count_next;
    end
  end

endmodule

[hdl/ctw_back.sv]
// TRB sequencer with ring slot, cycle bit, link insertion and result queue.
`timescale 1ns / 1ps
module ctw_back import ctw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [63:0] cfg_data,
  input  logic        cmd_valid,
  output logic        cmd_pop,
  input  cmd_t        cmd,
  output logic        empty,
  input  logic        pop,
  output trb_t        trb
);

  localparam logic [1:0] PH_SETUP  = 2'd0;
  localparam logic [1:0] PH_DATA   = 2'd1;
  localparam logic [1:0] PH_STATUS = 2'd2;

  logic [63:0]       ring_base;
  logic [SLOT_W-1:0] slot;
  logic              cycle;
  logic              busy;
  logic [1:0]        phase;
  logic [1:0]        phase_next;
  cmd_t              cur;

  trb_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;

  logic emit_go;
  logic at_last;
  logic finishing;
  logic pop_ok;
  trb_t emit_trb;

  assign at_last   = (slot == SLOT_W'(LAST_SLOT));
  assign emit_go   = busy && (count != 2'd2);
  assign finishing = emit_go && !at_last && (phase == PH_STATUS);
  assign cmd_pop   = cmd_valid && (!busy || finishing);
  assign pop_ok    = pop && !empty;
  assign empty     = (count == 2'd0);
  assign trb       = entries[rd_ptr];

  always_comb begin
    emit_trb.ring_slot = 6'(slot);
    emit_trb.last_trb  = 1'b0;
    phase_next         = phase;
    if (at_last) begin
      emit_trb.param_low    = ring_base[31:0];
      emit_trb.param_high   = ring_base[63:32];
      emit_trb.status_word  = 32'd0;
      emit_trb.control_word = ({26'd0, TRB_LINK} << 10) | BIT_TC | {31'd0, cycle};
    end else begin
      unique case (phase)
        PH_SETUP: begin
          emit_trb.param_low    = cur.setup_low;
          emit_trb.param_high   = cur.setup_high;
          emit_trb.status_word  = SETUP_LEN;
          emit_trb.control_word = cur.setup_ctl | {31'd0, cycle};
          phase_next            = cur.has_data ? PH_DATA : PH_STATUS;
        end
        PH_DATA: begin
          emit_trb.param_low    = cur.data_addr[31:0];
          emit_trb.param_high   = cur.data_addr[63:32];
          emit_trb.status_word  = {16'd0, cur.data_len};
          emit_trb.control_word = cur.data_ctl | {31'd0, cycle};
          phase_next            = PH_STATUS;
        end
        default: begin
          emit_trb.param_low    = 32'd0;
          emit_trb.param_high   = 32'd0;
          emit_trb.status_word  = 32'd0;
          emit_trb.control_word = cur.status_ctl | {31'd0, cycle};
          emit_trb.last_trb     = 1'b1;
          phase_next            = PH_SETUP;
        end
      endcase
    end
  end

  always_comb begin
    count_next = count;
    if (emit_go && !pop_ok) begin
      count_next = count + 2'd1;
    end else if (pop_ok && !emit_go) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd;
    end
    if (emit_go) begin
      entries[wr_ptr] <= emit_trb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_base <= 64'd0;
      slot      <= '0;
      cycle     <= 1'b1;
      busy      <= 1'b0;
      phase     <= PH_SETUP;
      wr_ptr    <= 1'b0;
      rd_ptr    <= 1'b0;
      count     <= 2'd0;
    end else begin
      if (cfg_valid) begin
        ring_base <= cfg_data;
      end
      if (emit_go) begin
        if (at_last) begin
          slot  <= '0;
          cycle <= ~cycle;
        end else begin
          slot <= slot + SLOT_W'(1);
        end
      end
      if (cmd_pop) begin
        busy  <= 1'b1;
        phase <= PH_SETUP;
      end else begin
        if (finishing) begin
          busy <= 1'b0;
        end
        if (emit_go && !at_last) begin
          phase <= phase_next;
        end
      end
      if (emit_go) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_ok) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count_next;
    end
  end

endmodule

[hdl/control_transfer_trb_writer.sv]
// Top level of the control transfer TRB writer for one transfer ring.
// Usage:
//   Request channel: drive request and raise push; the request is taken at a
//   clock edge where push is high and full is low. Up to two requests queue.
//   Result channel: while empty is low, trb holds the oldest TRB write; raise
//   pop to take it. Each request yields Setup, optional Data, and Status TRBs,
//   with a Link TRB inserted whenever the last ring slot is reached.
//   Configuration: cfg_data is written to ring_base when cfg_valid is high;
//   cfg_ready is always high. Write it only while the block is idle.
// Timing:
//   A taken request moves from the command queue into the sequencer's command
//   register. The sequencer emits one TRB per cycle while the result queue is
//   not full, set by the single-TRB write path; a request yields 2 to 4 TRBs.
// Reset (rst, synchronous): queues empty, slot 0, cycle bit 1, ring_base 0.
// Stall: when pop is held low the two-entry result queue fills, the
//   sequencer holds, then the command queue fills and full rises.
`timescale 1ns / 1ps
module control_transfer_trb_writer import ctw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  req_t        request,
  output logic        empty,
  input  logic        pop,
  output trb_t        trb,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  assign cfg_ready = 1'b1;

  ctw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .request   (request),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  ctw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .empty     (empty),
    .pop       (pop),
    .trb       (trb)
  );

endmodule

[hdl/ctw_checker.sv]
// Port-level checks for the control transfer TRB writer, bound to the top level.
`timescale 1ns / 1ps
module ctw_checker import ctw_pkg::*; (
  input logic clk,
  input logic rst,
  input logic full,
  input logic empty,
  input logic pop,
  input trb_t trb
);

  a_reset_clears: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not cleared by reset");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(trb))
    else $error("waiting TRB changed");

  a_last_is_status: assert property (@(posedge clk) disable iff (rst)
    !empty && trb.last_trb |-> trb.control_word[15:10] == TRB_STATUS)
    else $error("last flag on a non-status TRB");

  a_link_form: assert property (@(posedge clk) disable iff (rst)
    !empty && trb.control_word[15:10] == TRB_LINK
      |-> !trb.last_trb && trb.control_word[1]
        && trb.ring_slot == 6'(LAST_SLOT))
    else $error("malformed link TRB");

endmodule

bind control_transfer_trb_writer ctw_checker u_ctw_checker (
  .clk   (clk),
  .rst   (rst),
  .full  (full),
  .empty (empty),
  .pop   (pop),
  .trb   (trb)
);
